[rtl/scba_pkg.sv]
// shared constants for the size class block allocator
// status codes, request kinds and register indexes; no dependencies
`default_nettype none

package scba_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_ZERO     = 3'd1;
    localparam t_status ST_NOFIT    = 3'd2;
    localparam t_status ST_BADADDR  = 3'd3;
    localparam t_status ST_NOTALLOC = 3'd4;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int REQ_W      = 16;
    localparam int USED_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_BYTES = 2'd2;

    localparam logic [6:0]  RST_CLASS_COUNT = 7'd64;
    localparam logic [6:0]  RST_GRAIN       = 7'd8;
    localparam logic [16:0] RST_CLASS_BYTES = 17'd4096;

endpackage

`default_nettype wire

[rtl/scba_ram.sv]
// simple dual port memory, one write and one registered read per cycle
// no dependencies
`default_nettype none

module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/scba_divider.sv]
// restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module scba_divider #(
    parameter int DVD_W = 25,
    parameter int DVS_W = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient,
    output logic      [DVS_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_div;

    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? DVS_W'(w_trial - {1'b0, r_div}) : DVS_W'(w_trial);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

[rtl/size_class_block_allocator.sv]
// top level of the size class block allocator: sequencer, class tables, block stores
// depends on scba_pkg, scba_ram and scba_divider
`default_nettype none

// Fixed-block pool in size classes; class i holds blocks of grain*(i+1) bytes, each behind a
// header. One request is handled at a time, and a result beat comes out for every request
// that no register write cuts short. An allocate walks the classes from the smallest, one
// class per cycle, then pops a free block and works out its address. A free walks the classes
// the same way to find the one whose range holds the address, then runs the shared
// one-bit-per-cycle divider to get the block index and the header alignment. After reset and
// after every register write the pool is rebuilt: a sweep of the free stack and allocation
// marks, then for each active class two divider runs, a multiply and a table write, with no
// request taken meanwhile. Register writes are taken at any time and restart the rebuild.
module size_class_block_allocator #(
    parameter int MAX_CLASSES  = 64,
    parameter int MAX_BLOCKS   = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int ADDR_BITS    = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [scba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [scba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_kind,
    input  wire logic [scba_pkg::REQ_W-1:0]       i_req_size,
    input  wire logic [ADDR_BITS-1:0]             i_free_address,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output scba_pkg::t_status                     o_status,
    output logic      [ADDR_BITS-1:0]             o_block_address,
    output logic      [scba_pkg::USED_W-1:0]      o_used_bytes
);

    localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int NCLS_W = CLS_W + 1;
    localparam int BLK_W  = $clog2(MAX_BLOCKS);
    localparam int BCNT_W = BLK_W + 1;
    localparam int SIZE_W = $clog2(128 * MAX_CLASSES + 1);
    localparam int STR_W  = $clog2(128 * MAX_CLASSES + HEADER_BYTES + 1);
    localparam int A1_W   = ADDR_BITS + 1;
    localparam int TBL_W  = 2 * A1_W + BCNT_W;
    localparam int PROD_W = BCNT_W + STR_W;
    localparam int UW     = scba_pkg::USED_W;
    localparam logic [A1_W-1:0] LIMIT = {1'b1, {ADDR_BITS{1'b0}}};

    // sequencer states
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_BDIV1 = 4'd1;
    localparam logic [3:0] S_BDIV2 = 4'd2;
    localparam logic [3:0] S_BMUL  = 4'd3;
    localparam logic [3:0] S_BWR   = 4'd4;
    localparam logic [3:0] S_IDLE  = 4'd5;
    localparam logic [3:0] S_ASCAN = 4'd6;
    localparam logic [3:0] S_APOP  = 4'd7;
    localparam logic [3:0] S_AFIN  = 4'd8;
    localparam logic [3:0] S_FSCAN = 4'd9;
    localparam logic [3:0] S_FDIV  = 4'd10;
    localparam logic [3:0] S_FMARK = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // configuration registers
    logic [6:0]  r_cfg_cnt,   n_cfg_cnt;
    logic [6:0]  r_cfg_grain, n_cfg_grain;
    logic [16:0] r_cfg_bpc,   n_cfg_bpc;

    // sequencer and work registers
    logic [3:0]          r_state, n_state;
    logic [BCNT_W-1:0]   r_clr,   n_clr;
    logic [CLS_W-1:0]    r_cls,   n_cls;
    logic [SIZE_W-1:0]   r_size,  n_size;
    logic [A1_W-1:0]     r_base,  n_base;
    logic [BCNT_W-1:0]   r_first, n_first;
    logic [BCNT_W-1:0]   r_cnt,   n_cnt;
    logic [PROD_W-1:0]   r_prod,  n_prod;
    logic [16:0]         r_req,   n_req;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [BLK_W-1:0]    r_blk,   n_blk;
    scba_pkg::t_status   r_stat,  n_stat;
    logic [ADDR_BITS-1:0] r_gaddr, n_gaddr;
    logic [UW-1:0]       r_used,  n_used;
    logic                r_dstart, n_dstart;

    // result register
    logic                r_ovalid, n_ovalid;
    scba_pkg::t_status   r_o_status, n_o_status;
    logic [ADDR_BITS-1:0] r_o_addr, n_o_addr;
    logic [UW-1:0]       r_o_used, n_o_used;

    // derived configuration
    logic [8:0]          w_cnt9;
    logic [8:0]          w_n9;
    logic [NCLS_W-1:0]   w_n;
    logic [7:0]          w_g8;
    logic [7:0]          w_g;

    // memory ports
    logic                tbl_we;
    logic [TBL_W-1:0]    tbl_wdata;
    logic [TBL_W-1:0]    tbl_rd;
    logic                top_we;
    logic [BCNT_W-1:0]   top_wdata;
    logic [BCNT_W-1:0]   top_rd;
    logic                stk_we;
    logic [BLK_W-1:0]    stk_waddr;
    logic [BLK_W-1:0]    stk_wdata;
    logic [BLK_W-1:0]    stk_rd;
    logic                mrk_we;
    logic [BLK_W-1:0]    mrk_waddr;
    logic                mrk_wdata;
    logic                mrk_rd;

    // divider ports
    logic [A1_W-1:0]     d_dvd;
    logic [STR_W-1:0]    d_dvs;
    logic                d_done;
    logic [A1_W-1:0]     d_quo;
    logic [STR_W-1:0]    d_rem;

    // helpers
    logic [STR_W-1:0]    w_stride;
    logic [A1_W-1:0]     t_base;
    logic [A1_W-1:0]     t_end;
    logic [BCNT_W-1:0]   t_first;
    logic                w_last;
    logic                w_afit;
    logic [BLK_W-1:0]    w_aslot;
    logic [BLK_W-1:0]    w_aoff;
    logic                w_fin;
    logic [BLK_W-1:0]    w_fblk;
    logic [BLK_W-1:0]    w_fslot;
    logic [BCNT_W-1:0]   w_room;
    logic [A1_W-1:0]     w_end;
    logic                w_accept;
    logic                w_emit;

    // class count clamped to 1..MAX_CLASSES, grain rounded up to a multiple of four, at least four
    assign w_cnt9 = {2'b00, r_cfg_cnt};
    assign w_n9   = (r_cfg_cnt == 7'd0) ? 9'd1
                  : (w_cnt9 > 9'(MAX_CLASSES)) ? 9'(MAX_CLASSES) : w_cnt9;
    assign w_n    = w_n9[NCLS_W-1:0];
    assign w_g8   = ({1'b0, r_cfg_grain} + 8'd3) & 8'hFC;
    assign w_g    = (w_g8 < 8'd4) ? 8'd4 : w_g8;

    // class table word: base, end (exclusive), first block index
    assign t_base  = tbl_rd[TBL_W-1 -: A1_W];
    assign t_end   = tbl_rd[A1_W+BCNT_W-1 -: A1_W];
    assign t_first = tbl_rd[BCNT_W-1:0];

    assign w_stride = STR_W'(r_size) + STR_W'(HEADER_BYTES);
    assign w_last   = ({1'b0, r_cls} + NCLS_W'(1)) == w_n;
    assign w_afit   = (top_rd != '0) && (32'(r_size) >= 32'(r_req));
    assign w_aslot  = t_first[BLK_W-1:0] + top_rd[BLK_W-1:0] - BLK_W'(1);
    assign w_aoff   = stk_rd - r_first[BLK_W-1:0];
    assign w_fin    = (A1_W'(r_addr) >= t_base) && (A1_W'(r_addr) < t_end);
    assign w_fblk   = r_first[BLK_W-1:0] + d_quo[BLK_W-1:0];
    assign w_fslot  = r_first[BLK_W-1:0] + top_rd[BLK_W-1:0];
    assign w_room   = BCNT_W'(MAX_BLOCKS) - r_first;
    assign w_end    = r_base + A1_W'(r_prod);

    assign w_accept = i_in_valid && o_in_ready;
    assign w_emit   = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_cfg_cnt   = r_cfg_cnt;
        n_cfg_grain = r_cfg_grain;
        n_cfg_bpc   = r_cfg_bpc;
        n_state     = r_state;
        n_clr       = r_clr;
        n_cls       = r_cls;
        n_size      = r_size;
        n_base      = r_base;
        n_first     = r_first;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_req       = r_req;
        n_addr      = r_addr;
        n_blk       = r_blk;
        n_stat      = r_stat;
        n_gaddr     = r_gaddr;
        n_used      = r_used;
        n_dstart    = 1'b0;
        n_ovalid    = r_ovalid;
        n_o_status  = r_o_status;
        n_o_addr    = r_o_addr;
        n_o_used    = r_o_used;

        tbl_we    = 1'b0;
        tbl_wdata = {r_base, w_end, r_first};
        top_we    = 1'b0;
        top_wdata = r_cnt;
        stk_we    = 1'b0;
        stk_waddr = r_clr[BLK_W-1:0];
        stk_wdata = r_clr[BLK_W-1:0];
        mrk_we    = 1'b0;
        mrk_waddr = r_clr[BLK_W-1:0];
        mrk_wdata = 1'b0;

        // divider operands follow the state that runs it
        unique case (r_state)
            S_BDIV1: begin
                d_dvd = A1_W'(r_cfg_bpc);
                d_dvs = STR_W'(r_size);
            end
            S_BDIV2: begin
                d_dvd = LIMIT - r_base;
                d_dvs = w_stride;
            end
            default: begin
                d_dvd = A1_W'(r_addr) - r_base;
                d_dvs = w_stride;
            end
        endcase

        // result register drains independently of the sequencer
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            // sweep free stack to identity and clear allocation marks
            S_CLR: begin
                stk_we = 1'b1;
                mrk_we = 1'b1;
                n_clr  = r_clr + BCNT_W'(1);
                n_used = '0;
                if (r_clr == BCNT_W'(MAX_BLOCKS - 1)) begin
                    n_cls    = '0;
                    n_size   = SIZE_W'(w_g);
                    n_base   = '0;
                    n_first  = '0;
                    n_state  = S_BDIV1;
                    n_dstart = 1'b1;
                end
            end
            // block count from class bytes, cut to remaining block slots
            S_BDIV1: begin
                if (d_done) begin
                    n_cnt    = (d_quo > A1_W'(w_room)) ? w_room : BCNT_W'(d_quo);
                    n_state  = S_BDIV2;
                    n_dstart = 1'b1;
                end
            end
            // cut again to what still fits in the address space
            S_BDIV2: begin
                if (d_done) begin
                    if (d_quo < A1_W'(r_cnt)) begin
                        n_cnt = BCNT_W'(d_quo);
                    end
                    n_state = S_BMUL;
                end
            end
            S_BMUL: begin
                n_prod  = PROD_W'(r_cnt) * PROD_W'(w_stride);
                n_state = S_BWR;
            end
            S_BWR: begin
                tbl_we  = 1'b1;
                top_we  = 1'b1;
                n_base  = w_end;
                n_first = r_first + r_cnt;
                if (w_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_cls    = r_cls + CLS_W'(1);
                    n_size   = r_size + SIZE_W'(w_g);
                    n_state  = S_BDIV1;
                    n_dstart = 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_req   = (17'(i_req_size) + 17'd3) & ~17'd3;
                    n_addr  = i_free_address;
                    n_cls   = '0;
                    n_size  = SIZE_W'(w_g);
                    n_gaddr = '0;
                    if (i_kind == scba_pkg::KIND_FREE) begin
                        n_state = S_FSCAN;
                    end else if (i_req_size == '0) begin
                        n_stat  = scba_pkg::ST_ZERO;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ASCAN;
                    end
                end
            end
            // first class, smallest first, with a free block big enough
            S_ASCAN: begin
                if (w_afit) begin
                    top_we    = 1'b1;
                    top_wdata = top_rd - BCNT_W'(1);
                    n_base    = t_base;
                    n_first   = t_first;
                    n_state   = S_APOP;
                end else if (w_last) begin
                    n_stat  = scba_pkg::ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    n_cls  = r_cls + CLS_W'(1);
                    n_size = r_size + SIZE_W'(w_g);
                end
            end
            // popped block index is on the stack read port
            S_APOP: begin
                mrk_we    = 1'b1;
                mrk_waddr = stk_rd;
                mrk_wdata = 1'b1;
                n_prod    = PROD_W'(w_aoff) * PROD_W'(w_stride);
                n_state   = S_AFIN;
            end
            S_AFIN: begin
                n_gaddr = ADDR_BITS'(r_base + A1_W'(r_prod) + A1_W'(HEADER_BYTES));
                n_used  = r_used + UW'(r_size);
                n_stat  = scba_pkg::ST_OK;
                n_state = S_DONE;
            end
            // class whose range holds the address
            S_FSCAN: begin
                if (w_fin) begin
                    n_base   = t_base;
                    n_first  = t_first;
                    n_state  = S_FDIV;
                    n_dstart = 1'b1;
                end else if (w_last) begin
                    n_stat  = scba_pkg::ST_BADADDR;
                    n_state = S_DONE;
                end else begin
                    n_cls  = r_cls + CLS_W'(1);
                    n_size = r_size + SIZE_W'(w_g);
                end
            end
            // offset / stride gives the block, remainder must land on the data start
            S_FDIV: begin
                if (d_done) begin
                    if (d_rem == STR_W'(HEADER_BYTES)) begin
                        n_blk   = w_fblk;
                        n_state = S_FMARK;
                    end else begin
                        n_stat  = scba_pkg::ST_BADADDR;
                        n_state = S_DONE;
                    end
                end
            end
            S_FMARK: begin
                if (!mrk_rd) begin
                    n_stat = scba_pkg::ST_NOTALLOC;
                end else begin
                    mrk_we    = 1'b1;
                    mrk_waddr = r_blk;
                    mrk_wdata = 1'b0;
                    stk_we    = 1'b1;
                    stk_waddr = w_fslot;
                    stk_wdata = r_blk;
                    top_we    = 1'b1;
                    top_wdata = top_rd + BCNT_W'(1);
                    n_used    = r_used - UW'(r_size);
                    n_stat    = scba_pkg::ST_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_emit) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_stat;
                    n_o_addr   = r_gaddr;
                    n_o_used   = r_used;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
                n_clr   = '0;
            end
        endcase

        // any register write rebuilds the pool
        if (i_cfg_valid) begin
            priority case (i_cfg_index)
                scba_pkg::REG_CLASS_COUNT: n_cfg_cnt   = i_cfg_data[6:0];
                scba_pkg::REG_GRAIN:       n_cfg_grain = i_cfg_data[6:0];
                scba_pkg::REG_CLASS_BYTES: n_cfg_bpc   = i_cfg_data;
                default: ;
            endcase
            if (i_cfg_index == scba_pkg::REG_CLASS_COUNT ||
                i_cfg_index == scba_pkg::REG_GRAIN ||
                i_cfg_index == scba_pkg::REG_CLASS_BYTES) begin
                n_state  = S_CLR;
                n_clr    = '0;
                n_dstart = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cnt   <= scba_pkg::RST_CLASS_COUNT;
            r_cfg_grain <= scba_pkg::RST_GRAIN;
            r_cfg_bpc   <= scba_pkg::RST_CLASS_BYTES;
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_dstart    <= 1'b0;
            r_ovalid    <= 1'b0;
            r_used      <= '0;
        end else begin
            r_cfg_cnt   <= n_cfg_cnt;
            r_cfg_grain <= n_cfg_grain;
            r_cfg_bpc   <= n_cfg_bpc;
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_dstart    <= n_dstart;
            r_ovalid    <= n_ovalid;
            r_used      <= n_used;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_cls      <= n_cls;
        r_size     <= n_size;
        r_base     <= n_base;
        r_first    <= n_first;
        r_cnt      <= n_cnt;
        r_prod     <= n_prod;
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_blk      <= n_blk;
        r_stat     <= n_stat;
        r_gaddr    <= n_gaddr;
        r_o_status <= n_o_status;
        r_o_addr   <= n_o_addr;
        r_o_used   <= n_o_used;
    end

    // class tables read at the next class index so read data tracks r_cls
    scba_ram #(.WIDTH(TBL_W), .DEPTH(MAX_CLASSES)) u_class_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_cls),
        .i_wdata (tbl_wdata),
        .i_raddr (n_cls),
        .o_rdata (tbl_rd)
    );

    scba_ram #(.WIDTH(BCNT_W), .DEPTH(MAX_CLASSES)) u_stack_top (
        .i_clk   (i_clk),
        .i_we    (top_we),
        .i_waddr (r_cls),
        .i_wdata (top_wdata),
        .i_raddr (n_cls),
        .o_rdata (top_rd)
    );

    // free stacks of all classes, one region per class
    scba_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (w_aslot),
        .o_rdata (stk_rd)
    );

    // per block allocated flag, looked up by the free path
    scba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_alloc_mark (
        .i_clk   (i_clk),
        .i_we    (mrk_we),
        .i_waddr (mrk_waddr),
        .i_wdata (mrk_wdata),
        .i_raddr (w_fblk),
        .o_rdata (mrk_rd)
    );

    // shared divider for pool build and free lookup
    scba_divider #(.DVD_W(A1_W), .DVS_W(STR_W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_dstart),
        .i_dividend  (d_dvd),
        .i_divisor   (d_dvs),
        .o_done      (d_done),
        .o_quotient  (d_quo),
        .o_remainder (d_rem)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_status        = r_o_status;
    assign o_block_address = r_o_addr;
    assign o_used_bytes    = r_o_used;

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request beat accepted but sequencer stayed idle");

    // only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != scba_pkg::ST_OK) |-> (o_block_address == '0))
        else $error("failed request returned a block address");

    // divider launched only from a state that waits for it
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dstart |-> (r_state == S_BDIV1 || r_state == S_BDIV2 || r_state == S_FDIV))
        else $error("divider started outside a divide state");

    // a pop follows a successful class scan
    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APOP) |-> ($past(r_state) == S_ASCAN))
        else $error("stack pop without a class hit");

endmodule

`default_nettype wire

[tb/size_class_block_allocator_tb.sv]
// testbench for the size class block allocator: directed table, then random beats
// checked against a local pool predictor; depends on scba_pkg and the rtl top level
`timescale 1ns / 100ps

module size_class_block_allocator_tb;

    localparam int NCLS = 64;
    localparam int NBLK = 4096;
    localparam int HDR  = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [16:0]       i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_kind;
    logic [15:0]       i_req_size;
    logic [23:0]       i_free_address;
    logic              o_out_valid;
    logic              i_out_ready;
    scba_pkg::t_status o_status;
    logic [23:0]       o_block_address;
    logic [23:0]       o_used_bytes;

    size_class_block_allocator i_dut (.*);

    // expected result beat
    typedef struct packed {
        scba_pkg::t_status status;
        logic [23:0]       addr;
        logic [23:0]       used;
    } t_grant;

    // predictor copy of the pool
    logic [6:0]  pool_classes;
    logic [6:0]  pool_grain;
    logic [16:0] pool_bytes;
    int unsigned stack_store [NBLK];
    bit          taken [NBLK];
    int unsigned top_of [NCLS];
    longint      base_of [NCLS];
    int unsigned total_of [NCLS];
    int unsigned first_of [NCLS];
    int unsigned bsize_of [NCLS];
    int unsigned n_active;
    logic [23:0] used_now;

    t_grant      pending_grants[$];
    logic [23:0] live_blocks[$];   // data addresses currently held
    int          error_count;
    int          beats_checked;
    bit          idle_enable;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic rebuild_pool();
        int unsigned n, g, first, sz, cnt, room;
        longint lim, base, stride, fit;
        n = pool_classes; g = (pool_grain + 3) & ~3;
        if (n < 1) n = 1;
        if (n > NCLS) n = NCLS;
        if (g < 4) g = 4;
        n_active = n; lim = 64'd1 << 24; base = 0; first = 0;
        for (int k = 0; k < NBLK; k++) begin
            taken[k] = 0;
            stack_store[k] = 0;
        end
        for (int i = 0; i < NCLS; i++) begin
            sz = g * (i + 1);
            stride = sz + HDR;
            cnt = 0;
            if (i < n) begin
                room = NBLK - first;
                fit = (lim - base) / stride;
                cnt = pool_bytes / sz;
                if (cnt > room) cnt = room;
                if (cnt > fit) cnt = fit;
            end
            bsize_of[i] = sz; base_of[i] = base; first_of[i] = first;
            total_of[i] = cnt; top_of[i] = cnt;
            for (int k = 0; k < cnt; k++) stack_store[first + k] = first + k;
            base += cnt * stride;
            first += cnt;
        end
        used_now = 0;
        live_blocks.delete();
    endtask

    // predicts one request and updates the pool copy
    function automatic t_grant serve_request(input logic kind, input logic [15:0] rsz,
                                             input logic [23:0] fa);
        t_grant r;
        int unsigned sz, t, blk, slot;
        longint stride, lo, hi, off;
        r = '0;
        if (kind == scba_pkg::KIND_ALLOC) begin
            sz = rsz;
            if (sz == 0) r.status = scba_pkg::ST_ZERO;
            else begin
                sz = (sz + 3) & ~3;
                r.status = scba_pkg::ST_NOFIT;
                for (int i = 0; i < n_active; i++) begin
                    if (top_of[i] == 0 || bsize_of[i] < sz) continue;
                    t = top_of[i] - 1;
                    slot = (first_of[i] + t) % NBLK;
                    blk = stack_store[slot] % NBLK;
                    stride = bsize_of[i] + HDR;
                    top_of[i] = t;
                    taken[blk] = 1;
                    r.addr = base_of[i] + (blk - first_of[i]) * stride + HDR;
                    used_now = used_now + bsize_of[i];
                    r.status = scba_pkg::ST_OK;
                    live_blocks.push_back(r.addr);
                    break;
                end
            end
        end else begin
            r.status = scba_pkg::ST_BADADDR;
            for (int i = 0; i < n_active; i++) begin
                stride = bsize_of[i] + HDR;
                lo = base_of[i];
                hi = lo + total_of[i] * stride;
                if (fa >= lo && fa < hi) begin
                    off = fa - lo;
                    if (off % stride == HDR) begin
                        blk = (first_of[i] + off / stride) % NBLK;
                        if (!taken[blk]) r.status = scba_pkg::ST_NOTALLOC;
                        else begin
                            slot = (first_of[i] + top_of[i]) % NBLK;
                            taken[blk] = 0;
                            stack_store[slot] = blk;
                            top_of[i]++;
                            used_now = used_now - bsize_of[i];
                            r.status = scba_pkg::ST_OK;
                            foreach (live_blocks[j])
                                if (live_blocks[j] == fa) begin
                                    live_blocks.delete(j);
                                    break;
                                end
                        end
                    end
                    break;
                end
            end
        end
        r.used = used_now;
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // random idle gaps, only while idle_enable is set
    task automatic maybe_idle();
        if (idle_enable && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            scba_pkg::REG_CLASS_COUNT: pool_classes = val[6:0];
            scba_pkg::REG_GRAIN:       pool_grain = val[6:0];
            default:                   pool_bytes = val;
        endcase
        rebuild_pool();
    endtask

    // send one request beat; a typed-in expectation, if given, is checked against the predictor
    task automatic send_request(input logic kind, input logic [15:0] rsz,
                                input logic [23:0] fa, input bit typed,
                                input scba_pkg::t_status want_st,
                                input logic [23:0] want_addr);
        t_grant g;
        @(negedge i_clk);
        maybe_idle();
        i_in_valid <= 1; i_kind <= kind; i_req_size <= rsz; i_free_address <= fa;
        do @(posedge i_clk); while (!o_in_ready);
        g = serve_request(kind, rsz, fa);
        if (typed && (g.status !== want_st || g.addr !== want_addr))
            report_mismatch("directed table vs predictor", {g.status, g.addr},
                            {want_st, want_addr});
        pending_grants.push_back(g);
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    task automatic drain_results();
        wait (pending_grants.size() == 0);
        // a rebuild or trailing work needs no result, so wait a little
        repeat (200) @(negedge i_clk);
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial begin
        t_grant w;
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_enable && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            i_out_ready <= 1;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (pending_grants.size() == 0) begin
                    report_mismatch("unexpected result beat", o_status, 0);
                end else begin
                    w = pending_grants.pop_front();
                    beats_checked++;
                    if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                    if (o_block_address !== w.addr)
                        report_mismatch("block_address", o_block_address, w.addr);
                    if (o_used_bytes !== w.used)
                        report_mismatch("used_bytes", o_used_bytes, w.used);
                end
            end
        end
    end

    // one random request: mostly allocates and frees of live blocks
    task automatic random_request();
        int pick;
        logic [23:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_request(scba_pkg::KIND_ALLOC, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                         : 16'($urandom_range(1, 600)), 24'($urandom), 0,
                         scba_pkg::ST_OK, 0);
        else if (pick < 85 && live_blocks.size() > 0) begin
            a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            send_request(scba_pkg::KIND_FREE, 16'($urandom), a, 0, scba_pkg::ST_OK, 0);
        end else if (pick < 92 && live_blocks.size() > 0) begin
            // neighbor of a live block, usually misaligned (offset -5 to +6)
            a = live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                + 24'($urandom_range(1, 12)) - 24'd6;
            send_request(scba_pkg::KIND_FREE, 16'($urandom), a, 0, scba_pkg::ST_OK, 0);
        end else
            send_request(scba_pkg::KIND_FREE, 16'($urandom), 24'($urandom), 0,
                         scba_pkg::ST_OK, 0);
    endtask

    typedef struct {
        logic              kind;
        logic [15:0]       rsz;
        logic [23:0]       fa;
        bit                typed;
        scba_pkg::t_status st;
        logic [23:0]       addr;
    } t_row;

    // directed rows after reset (64 classes, grain 8, 4096 bytes per class)
    t_row table_rows[] = '{
        '{scba_pkg::KIND_ALLOC, 16'd0,    24'd0,      1, scba_pkg::ST_ZERO,     24'd0},
        '{scba_pkg::KIND_ALLOC, 16'd1,    24'hFFFFFF, 1, scba_pkg::ST_OK,       24'd8184},
        '{scba_pkg::KIND_ALLOC, 16'd8,    24'd0,      1, scba_pkg::ST_OK,       24'd8168},
        '{scba_pkg::KIND_ALLOC, 16'd9,    24'd0,      0, scba_pkg::ST_OK,       24'd0},
        '{scba_pkg::KIND_ALLOC, 16'd12,   24'd0,      0, scba_pkg::ST_OK,       24'd0},
        '{scba_pkg::KIND_ALLOC, 16'hFFFF, 24'd0,      1, scba_pkg::ST_NOFIT,    24'd0},
        '{scba_pkg::KIND_ALLOC, 16'd512,  24'd0,      0, scba_pkg::ST_OK,       24'd0},
        '{scba_pkg::KIND_ALLOC, 16'd513,  24'd0,      1, scba_pkg::ST_NOFIT,    24'd0},
        '{scba_pkg::KIND_FREE,  16'hFFFF, 24'd8184,   1, scba_pkg::ST_OK,       24'd0},
        '{scba_pkg::KIND_FREE,  16'd0,    24'd8184,   1, scba_pkg::ST_NOTALLOC, 24'd0},
        '{scba_pkg::KIND_FREE,  16'd0,    24'd8185,   1, scba_pkg::ST_BADADDR,  24'd0},
        '{scba_pkg::KIND_FREE,  16'd0,    24'd0,      1, scba_pkg::ST_BADADDR,  24'd0},
        '{scba_pkg::KIND_FREE,  16'd0,    24'hFFFFFF, 1, scba_pkg::ST_BADADDR,  24'd0},
        '{scba_pkg::KIND_FREE,  16'd0,    24'd8168,   1, scba_pkg::ST_OK,       24'd0},
        '{scba_pkg::KIND_FREE,  16'd0,    24'd4096,   1, scba_pkg::ST_BADADDR,  24'd0}
    };

    initial begin
        i_rst_n = 0; i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_in_valid = 0; i_kind = 0; i_req_size = 0; i_free_address = 0;
        error_count = 0; beats_checked = 0; idle_enable = 1;
        pool_classes = scba_pkg::RST_CLASS_COUNT;
        pool_grain   = scba_pkg::RST_GRAIN;
        pool_bytes   = scba_pkg::RST_CLASS_BYTES;
        rebuild_pool();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        foreach (table_rows[r])
            send_request(table_rows[r].kind, table_rows[r].rsz, table_rows[r].fa,
                         table_rows[r].typed, table_rows[r].st, table_rows[r].addr);
        // pressure: hold the sender until everything is back
        drain_results();

        // settings: extremes first, odd values too (zero class count, unaligned grain)
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(scba_pkg::REG_CLASS_COUNT, 17'd1);
                    write_reg(scba_pkg::REG_GRAIN, 17'd4);
                    write_reg(scba_pkg::REG_CLASS_BYTES, 17'd8);
                end
                1: begin
                    write_reg(scba_pkg::REG_CLASS_COUNT, 17'h7F);
                    write_reg(scba_pkg::REG_GRAIN, 17'd64);
                    write_reg(scba_pkg::REG_CLASS_BYTES, 17'h1FFFF);
                end
                2: begin
                    write_reg(scba_pkg::REG_CLASS_COUNT, 17'd0);
                    write_reg(scba_pkg::REG_GRAIN, 17'd0);
                    write_reg(scba_pkg::REG_CLASS_BYTES, 17'd65536);
                end
                3: begin
                    write_reg(scba_pkg::REG_CLASS_COUNT, 17'd3);
                    write_reg(scba_pkg::REG_GRAIN, 17'd5);
                    write_reg(scba_pkg::REG_CLASS_BYTES, 17'd40);
                end
                7: begin
                    write_reg(scba_pkg::REG_CLASS_COUNT, 17'(scba_pkg::RST_CLASS_COUNT));
                    write_reg(scba_pkg::REG_GRAIN, 17'(scba_pkg::RST_GRAIN));
                    write_reg(scba_pkg::REG_CLASS_BYTES, scba_pkg::RST_CLASS_BYTES);
                end
                default: begin
                    write_reg(scba_pkg::REG_CLASS_COUNT, 17'($urandom_range(1, 12)));
                    write_reg(scba_pkg::REG_GRAIN, 17'($urandom_range(0, 127)));
                    write_reg(scba_pkg::REG_CLASS_BYTES, 17'($urandom_range(8, 300)));
                end
            endcase
            if (ph == 7) idle_enable = 0;   // final stretch runs flat out
            repeat (190) random_request();
            drain_results();
        end
        $display("covered %0d result beats over eight pool settings plus reset defaults",
                 beats_checked);
        $display("including zero size, no fit, bad address, double free and extremes");
        if (error_count == 0)
            $display("size_class_block_allocator_tb: clean");
        else
            $display("size_class_block_allocator_tb: errors");
        $finish;
    end

    initial begin
        #40ms;
        $display("timeout with %0d beats outstanding", pending_grants.size());
        $display("size_class_block_allocator_tb: errors");
        $finish;
    end

endmodule
